/* rtl/crt_pkg.sv */
// Package: constants, status codes and slot record widths for the chunk reassembly tracker.
`timescale 1ns / 1ps
package crt_pkg;
    localparam int TRANSFER_SLOTS_DEF = 16;
    localparam int CHUNK_SLOTS_DEF    = 64;
    localparam logic [6:0]  MAX_CHUNKS_RST   = 7'd64;
    localparam logic [31:0] MAX_BYTES_RST    = 32'd1048576;
    localparam logic [4:0]  MAX_INFLIGHT_RST = 5'd16;

    localparam logic [1:0] CFG_MAX_CHUNKS   = 2'd0;
    localparam logic [1:0] CFG_MAX_BYTES    = 2'd1;
    localparam logic [1:0] CFG_MAX_INFLIGHT = 2'd2;

    typedef enum logic [3:0] {
        ST_PENDING    = 4'd0,
        ST_DUPLICATE  = 4'd1,
        ST_COMPLETE   = 4'd2,
        ST_BAD_INDEX  = 4'd3,
        ST_COUNT_CAP  = 4'd4,
        ST_LENGTH_CAP = 4'd5,
        ST_TABLE_FULL = 4'd6,
        ST_MISMATCH   = 4'd7,
        ST_BYTES_CAP  = 4'd8,
        ST_LEN_MISM   = 4'd9
    } t_status;

    // key part and progress part of one slot record
    localparam int KEY_W = 192;
    localparam int PRG_W = 32 + 7 + 33 + 7 + 64;
endpackage

/* rtl/crt_ram.sv */
// Generic single-port write, single-port read RAM with registered read data.
`timescale 1ns / 1ps
module crt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/chunk_reassembly_tracker_top.sv */
// Top level: chunk header checks, slot search and per-slot progress update.
// From acceptance: limit checks, then a slot search with one key-memory read a cycle,
// then progress read, update and write back, then the result is held until taken.
// One request at a time: a new request is taken only once the result of the last has been
// taken; a limit-check rejection skips the search and goes straight to the result.
// Reset: synchronous active low; clears slot valid bits, open count, limits to defaults.
`timescale 1ns / 1ps
module chunk_reassembly_tracker_top
    import crt_pkg::*;
#(
    parameter int TRANSFER_SLOTS = TRANSFER_SLOTS_DEF,
    parameter int CHUNK_SLOTS    = CHUNK_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_sender_tag,
    input  logic [63:0] i_xfer_id_hi,
    input  logic [63:0] i_xfer_id_lo,
    input  logic [31:0] i_chunk_number,
    input  logic [31:0] i_chunk_total,
    input  logic [31:0] i_declared_length,
    input  logic [31:0] i_chunk_length,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_status,
    output logic        o_ok,
    output logic [3:0]  o_slot,
    output logic [31:0] o_assembled_length
);
    localparam int SW = (TRANSFER_SLOTS > 1) ? $clog2(TRANSFER_SLOTS) : 1;
    localparam int CW = $clog2(TRANSFER_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_SEARCH, S_DECIDE, S_UPDATE, S_OUT
    } t_state;

    t_state r_state;
    logic [6:0]  r_max_chunks;
    logic [31:0] r_max_bytes;
    logic [4:0]  r_max_inflight;
    logic [TRANSFER_SLOTS-1:0] r_valid_bits;
    logic [CW-1:0] r_open;

    // captured request
    logic [63:0] r_tag, r_hi, r_lo;
    logic [31:0] r_num, r_tot, r_decl, r_clen;

    // search
    logic [SW:0]   r_idx;      // read address issued
    logic          r_cmp_vld;  // key data for r_cmp_idx present
    logic [SW-1:0] r_cmp_idx;
    logic          r_found;
    logic [SW-1:0] r_found_idx;
    logic          r_free;
    logic [SW-1:0] r_free_idx;
    logic [SW-1:0] r_slot;
    logic          r_new;

    // result
    logic [3:0]  r_status;
    logic [31:0] r_alen;

    // memories
    logic          key_we, prg_we;
    logic [SW-1:0] key_ra, prg_addr;
    logic [KEY_W-1:0] key_rd, key_wd;
    logic [PRG_W-1:0] prg_rd, prg_wd;

    crt_ram #(.WIDTH(KEY_W), .DEPTH(TRANSFER_SLOTS)) u_key (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(r_slot), .i_wdata(key_wd),
        .i_raddr(key_ra), .o_rdata(key_rd)
    );
    crt_ram #(.WIDTH(PRG_W), .DEPTH(TRANSFER_SLOTS)) u_prg (
        .i_clk(i_clk), .i_we(prg_we), .i_waddr(r_slot), .i_wdata(prg_wd),
        .i_raddr(prg_addr), .o_rdata(prg_rd)
    );

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_status    = r_status;
    assign o_ok        = (r_status <= ST_COMPLETE);
    assign o_slot      = 4'(r_slot);
    assign o_assembled_length = r_alen;

    assign key_ra   = r_idx[SW-1:0];
    assign prg_addr = r_slot;
    assign key_wd   = {r_tag, r_hi, r_lo};

    // unpack progress record
    logic [31:0] p_decl;
    logic [6:0]  p_tot, p_cnt;
    logic [32:0] p_bytes;
    logic [63:0] p_map;
    assign {p_decl, p_tot, p_bytes, p_cnt, p_map} = prg_rd;

    // progress update for a hit or fresh slot
    logic [31:0] c_decl;
    logic [6:0]  c_tot, c_cnt;
    logic [32:0] c_bytes, c_sum;
    logic [63:0] c_map, c_bit;
    logic        c_mism;
    always_comb begin
        c_decl  = r_new ? r_decl : p_decl;
        c_tot   = r_new ? r_tot[6:0] : p_tot;
        c_bytes = r_new ? 33'd0 : p_bytes;
        c_cnt   = r_new ? 7'd0 : p_cnt;
        c_map   = r_new ? 64'd0 : p_map;
        c_mism  = ({25'd0, c_tot} != r_tot) || (c_decl != r_decl);
        c_bit   = 64'd1 << r_num[5:0];
        c_sum   = c_bytes + {1'b0, r_clen};
    end

    logic first_cycle_ok;
    logic [CW-1:0] open_dec;
    assign open_dec = (r_open != '0) ? r_open - CW'(1) : r_open;
    assign first_cycle_ok = 1'b1;

    always_ff @(posedge i_clk) begin
        key_we <= 1'b0;
        prg_we <= 1'b0;
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_max_chunks   <= MAX_CHUNKS_RST;
            r_max_bytes    <= MAX_BYTES_RST;
            r_max_inflight <= MAX_INFLIGHT_RST;
            r_valid_bits   <= '0;
            r_open         <= '0;
            r_status       <= ST_PENDING;
            r_slot         <= '0;
            r_alen         <= '0;
        end else begin
            case (r_state)
                // take configuration or a request
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        case (i_cfg_index)
                            CFG_MAX_CHUNKS:   r_max_chunks   <= i_cfg_data[6:0];
                            CFG_MAX_BYTES:    r_max_bytes    <= i_cfg_data;
                            CFG_MAX_INFLIGHT: r_max_inflight <= i_cfg_data[4:0];
                            default: ;
                        endcase
                    end
                    if (i_valid) begin
                        r_tag <= i_sender_tag; r_hi <= i_xfer_id_hi; r_lo <= i_xfer_id_lo;
                        r_num <= i_chunk_number; r_tot <= i_chunk_total;
                        r_decl <= i_declared_length; r_clen <= i_chunk_length;
                        r_state <= S_CHECK;
                    end
                end
                // limit checks before any lookup
                S_CHECK: begin
                    r_slot <= '0;
                    r_alen <= '0;
                    r_idx <= '0;
                    r_cmp_vld <= 1'b0;
                    r_found <= 1'b0; r_free <= 1'b0;
                    r_found_idx <= '0; r_free_idx <= '0;
                    if (r_tot == 32'd0 || r_num >= r_tot) begin
                        r_status <= ST_BAD_INDEX; r_state <= S_OUT;
                    end else if (r_tot > {25'd0, r_max_chunks} || r_tot > CHUNK_SLOTS) begin
                        r_status <= ST_COUNT_CAP; r_state <= S_OUT;
                    end else if (r_decl > r_max_bytes) begin
                        r_status <= ST_LENGTH_CAP; r_state <= S_OUT;
                    end else begin
                        r_state <= S_SEARCH;
                    end
                end
                // walk the key memory one slot a cycle
                S_SEARCH: begin
                    if (r_idx < (SW+1)'(TRANSFER_SLOTS)) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    r_cmp_vld <= (r_idx < (SW+1)'(TRANSFER_SLOTS));
                    r_cmp_idx <= r_idx[SW-1:0];
                    if (r_cmp_vld) begin
                        if (r_valid_bits[r_cmp_idx]) begin
                            if (!r_found && key_rd == key_wd) begin
                                r_found <= 1'b1; r_found_idx <= r_cmp_idx;
                            end
                        end else if (!r_free) begin
                            r_free <= 1'b1; r_free_idx <= r_cmp_idx;
                        end
                    end
                    if (r_cmp_vld && r_cmp_idx == SW'(TRANSFER_SLOTS - 1)) begin
                        r_state <= S_DECIDE;
                    end
                end
                // hit, allocate or refuse; sets the slot that addresses the progress read
                S_DECIDE: begin
                    if (r_found) begin
                        r_slot <= r_found_idx; r_new <= 1'b0; r_state <= S_UPDATE;
                    end else if ({{(32-CW){1'b0}}, r_open} >= {27'd0, r_max_inflight}
                                 || !r_free) begin
                        r_status <= ST_TABLE_FULL; r_state <= S_OUT;
                    end else begin
                        r_slot <= r_free_idx; r_new <= 1'b1;
                        r_valid_bits[r_free_idx] <= 1'b1;
                        r_open <= r_open + CW'(1);
                        key_we <= 1'b1;
                        r_state <= S_UPDATE;
                    end
                end
                // wait for read data, then modify and write back
                S_UPDATE: begin
                    if (r_status == ST_PENDING && first_cycle_ok && !r_cmp_vld) begin
                        r_cmp_vld <= 1'b1;
                    end else begin
                        r_state <= S_OUT;
                        prg_we <= 1'b1;
                        if (c_mism) begin
                            r_status <= ST_MISMATCH;
                            prg_wd <= {c_decl, c_tot, c_bytes, c_cnt, c_map};
                        end else if ((c_map & c_bit) != '0) begin
                            r_status <= ST_DUPLICATE;
                            prg_wd <= {c_decl, c_tot, c_bytes, c_cnt, c_map};
                        end else if (c_sum > {1'b0, r_max_bytes}) begin
                            r_status <= ST_BYTES_CAP;
                            prg_wd <= {c_decl, c_tot, c_sum, c_cnt, c_map};
                            r_valid_bits[r_slot] <= 1'b0;
                            r_open <= open_dec;
                        end else if (c_cnt + 7'd1 != c_tot) begin
                            r_status <= ST_PENDING;
                            prg_wd <= {c_decl, c_tot, c_sum, c_cnt + 7'd1, c_map | c_bit};
                        end else begin
                            prg_wd <= {c_decl, c_tot, c_sum, c_cnt + 7'd1, c_map | c_bit};
                            r_valid_bits[r_slot] <= 1'b0;
                            r_open <= open_dec;
                            if (c_decl != 32'd0 && c_sum != {1'b0, c_decl}) begin
                                r_status <= ST_LEN_MISM;
                            end else begin
                                r_status <= ST_COMPLETE;
                                r_alen <= c_sum[31:0];
                            end
                        end
                    end
                end
                // hold the result until taken
                S_OUT: begin
                    if (!i_stall) begin
                        r_state  <= S_IDLE;
                        r_status <= ST_PENDING;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // open count tracks the valid bits
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> $countones(r_valid_bits) == int'(r_open))
        else $error("open count out of step with valid bits");
    // complete carries nonzero-length only on complete
    a_alen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_COMPLETE) |-> o_assembled_length == 32'd0)
        else $error("assembled length on non-complete result");
    // bad-index and table-full refusals never touch a slot
    a_noslot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_BAD_INDEX || o_status == ST_TABLE_FULL)) |-> o_slot == 4'd0)
        else $error("slot reported on refused request");
endmodule

/* verif/chunk_reassembly_tracker_top_tb.sv */
// Self-checking testbench for the chunk reassembly tracker: predicted status per chunk header.
`timescale 1ns / 1ps
module chunk_reassembly_tracker_top_tb;
    import crt_pkg::*;

    typedef struct packed {
        logic [63:0] tag;
        logic [63:0] id_hi;
        logic [63:0] id_lo;
        logic [31:0] num;
        logic [31:0] tot;
        logic [31:0] decl;
        logic [31:0] clen;
    } t_chunk;

    typedef struct packed {
        logic [3:0]  status;
        logic        ok;
        logic [3:0]  slot;
        logic [31:0] alen;
    } t_verdict;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_sender_tag;
    logic [63:0] i_xfer_id_hi;
    logic [63:0] i_xfer_id_lo;
    logic [31:0] i_chunk_number;
    logic [31:0] i_chunk_total;
    logic [31:0] i_declared_length;
    logic [31:0] i_chunk_length;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        o_valid;
    logic        i_stall;
    logic [3:0]  o_status;
    logic        o_ok;
    logic [3:0]  o_slot;
    logic [31:0] o_assembled_length;

    chunk_reassembly_tracker_top u_top (.*);

    // predictor state
    logic [6:0]  lim_chunks;
    logic [31:0] lim_bytes;
    logic [4:0]  lim_inflight;
    logic        sv_valid [16];
    logic [63:0] sv_tag [16];
    logic [63:0] sv_hi [16];
    logic [63:0] sv_lo [16];
    logic [31:0] sv_tot [16];
    logic [31:0] sv_decl [16];
    logic [32:0] sv_bytes [16];
    logic [6:0]  sv_count [16];
    logic [63:0] sv_map [16];
    logic [4:0]  open_xfers;

    t_chunk   pending_chunks[$];
    t_verdict expected_verdicts[$];
    int       mismatch_count;
    int       sent_count;
    bit       quiet_phase;
    bit       hold_off_req;
    bit       failed_timeout;

    function automatic t_verdict make_verdict(t_status st, int sl, logic [31:0] len);
        t_verdict v;
        v.status = st;
        v.ok     = (st == ST_PENDING || st == ST_DUPLICATE || st == ST_COMPLETE);
        v.slot   = sl[3:0];
        v.alen   = len;
        return v;
    endfunction

    // work out the status of one header and update the slot table
    function automatic t_verdict track_chunk(t_chunk c);
        int found;
        int free_s;
        logic [32:0] sum;
        found  = 16;
        free_s = 16;
        if (c.tot == 0 || c.num >= c.tot) return make_verdict(ST_BAD_INDEX, 0, 0);
        if (c.tot > {25'd0, lim_chunks} || c.tot > 64) return make_verdict(ST_COUNT_CAP, 0, 0);
        if (c.decl > lim_bytes) return make_verdict(ST_LENGTH_CAP, 0, 0);
        for (int s = 0; s < 16; s++) begin
            if (sv_valid[s]) begin
                if (found == 16 && sv_tag[s] == c.tag && sv_hi[s] == c.id_hi
                    && sv_lo[s] == c.id_lo) found = s;
            end else if (free_s == 16) begin
                free_s = s;
            end
        end
        if (found == 16) begin
            if (open_xfers >= lim_inflight || free_s == 16)
                return make_verdict(ST_TABLE_FULL, 0, 0);
            found = free_s;
            sv_valid[found] = 1'b1;
            sv_tag[found]   = c.tag;
            sv_hi[found]    = c.id_hi;
            sv_lo[found]    = c.id_lo;
            sv_tot[found]   = c.tot;
            sv_decl[found]  = c.decl;
            sv_bytes[found] = '0;
            sv_count[found] = '0;
            sv_map[found]   = '0;
            open_xfers++;
        end
        if (sv_tot[found] != c.tot || sv_decl[found] != c.decl)
            return make_verdict(ST_MISMATCH, found, 0);
        if (sv_map[found][c.num[5:0]]) return make_verdict(ST_DUPLICATE, found, 0);
        sum = sv_bytes[found] + {1'b0, c.clen};
        sv_bytes[found] = sum;
        if (sum > {1'b0, lim_bytes}) begin
            sv_valid[found] = 1'b0;
            if (open_xfers > 0) open_xfers--;
            return make_verdict(ST_BYTES_CAP, found, 0);
        end
        sv_map[found][c.num[5:0]] = 1'b1;
        sv_count[found]++;
        if ({25'd0, sv_count[found]} != sv_tot[found]) return make_verdict(ST_PENDING, found, 0);
        sv_valid[found] = 1'b0;
        if (open_xfers > 0) open_xfers--;
        if (sv_decl[found] != 0 && sum != {1'b0, sv_decl[found]})
            return make_verdict(ST_LEN_MISM, found, 0);
        return make_verdict(ST_COMPLETE, found, sum[31:0]);
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // timeout
    initial begin
        #50ms;
        failed_timeout = 1'b1;
        $display("end of test: mismatches");
        $finish;
    end

    // driver: offer queued headers with random gaps
    int send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_verdicts.push_back(track_chunk(pending_chunks.pop_front()));
                sent_count++;
            end
            if (i_valid && o_stall) begin
                // hold the stalled request
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid  <= 1'b0;
            end else if (pending_chunks.size() > 0 &&
                         !(i_valid && !o_stall && pending_chunks.size() == 0)) begin
                if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                    send_gap <= $urandom_range(1, 17) - 1;
                    i_valid  <= 1'b0;
                end else begin
                    i_valid           <= 1'b1;
                    i_sender_tag      <= pending_chunks[0].tag;
                    i_xfer_id_hi      <= pending_chunks[0].id_hi;
                    i_xfer_id_lo      <= pending_chunks[0].id_lo;
                    i_chunk_number    <= pending_chunks[0].num;
                    i_chunk_total     <= pending_chunks[0].tot;
                    i_declared_length <= pending_chunks[0].decl;
                    i_chunk_length    <= pending_chunks[0].clen;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall: random bursts, plus one long hold-off on request
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (hold_off_req) begin
            i_stall      <= 1'b1;
            stall_left   <= 400;
            hold_off_req <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 17) - 1;
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_verdicts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result status=%0d slot=%0d", o_status, o_slot);
            end else begin
                t_verdict e;
                e = expected_verdicts.pop_front();
                if (o_status !== e.status || o_ok !== e.ok || o_slot !== e.slot
                    || o_assembled_length !== e.alen) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp st=%0d ok=%0d slot=%0d len=%0d, got st=%0d ok=%0d slot=%0d len=%0d",
                                 e.status, e.ok, e.slot, e.alen,
                                 o_status, o_ok, o_slot, o_assembled_length);
                end
            end
        end
    end

    task automatic write_limit(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MAX_CHUNKS:   lim_chunks   = val[6:0];
            CFG_MAX_BYTES:    lim_bytes    = val;
            CFG_MAX_INFLIGHT: lim_inflight = val[4:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_chunks.size() > 0 || i_valid || expected_verdicts.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic t_chunk mk(logic [63:0] tag, logic [63:0] hi, logic [63:0] lo,
                                  logic [31:0] num, logic [31:0] tot, logic [31:0] decl,
                                  logic [31:0] clen);
        t_chunk c;
        c = '{tag, hi, lo, num, tot, decl, clen};
        return c;
    endfunction

    // queue one whole transfer in shuffled order, with sometimes a duplicate or a stray
    task automatic queue_transfer(int key_pool);
        t_chunk c;
        int tot;
        int order[$];
        logic [31:0] decl;
        logic [31:0] per;
        tot = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 6);
        c.tag   = key_pool ? {60'd0, 4'($urandom_range(0, 3))} : {$urandom, $urandom};
        c.id_hi = key_pool ? 64'd7 : {$urandom, $urandom};
        c.id_lo = key_pool ? {56'd0, 8'($urandom_range(0, 15))} : {$urandom, $urandom};
        per     = $urandom_range(0, 300);
        decl    = ($urandom_range(0, 2) == 0) ? 32'd0 : per * tot
                  + (($urandom_range(0, 4) == 0) ? 1 : 0);
        for (int i = 0; i < tot; i++) order.push_back(i);
        order.shuffle();
        foreach (order[i]) begin
            c.num  = order[i];
            c.tot  = tot;
            c.decl = decl;
            c.clen = per;
            if ($urandom_range(0, 19) == 0) c.tot = tot + 1;
            if ($urandom_range(0, 19) == 0) c.clen = $urandom;
            pending_chunks.push_back(c);
            if ($urandom_range(0, 9) == 0) pending_chunks.push_back(c);
        end
    endtask

    function automatic t_chunk noise_chunk();
        t_chunk c;
        c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 1)) c.tot = $urandom_range(0, 70);
        if ($urandom_range(0, 1)) c.num = $urandom_range(0, 70);
        if ($urandom_range(0, 1)) c.decl = $urandom_range(0, 2000000);
        return c;
    endfunction

    task automatic random_phase(int n);
        int target;
        target = sent_count + n;
        while (sent_count + pending_chunks.size() < target) begin
            if ($urandom_range(0, 4) == 0) pending_chunks.push_back(noise_chunk());
            else queue_transfer($urandom_range(0, 1));
        end
        drain();
    endtask

    initial begin
        logic [63:0] ones;
        ones              = '1;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_stall           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = CFG_MAX_CHUNKS;
        i_cfg_data        = '0;
        i_sender_tag      = '0;
        i_xfer_id_hi      = '0;
        i_xfer_id_lo      = '0;
        i_chunk_number    = '0;
        i_chunk_total     = '0;
        i_declared_length = '0;
        i_chunk_length    = '0;
        mismatch_count    = 0;
        sent_count        = 0;
        quiet_phase       = 1'b0;
        hold_off_req      = 1'b0;
        failed_timeout    = 1'b0;
        lim_chunks        = MAX_CHUNKS_RST;
        lim_bytes         = MAX_BYTES_RST;
        lim_inflight      = MAX_INFLIGHT_RST;
        open_xfers        = '0;
        for (int s = 0; s < 16; s++) sv_valid[s] = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: index checks, caps, duplicates, completion, mismatch, bytes cap, length mismatch, table full
        pending_chunks.push_back(mk(0, 0, 0, 0, 0, 0, 0));
        pending_chunks.push_back(mk(0, 0, 0, 3, 3, 0, 0));
        pending_chunks.push_back(mk(0, 0, 0, ones[31:0], ones[31:0], 0, 0));
        pending_chunks.push_back(mk(0, 0, 0, 0, 65, 0, 0));
        pending_chunks.push_back(mk(0, 0, 0, 0, 2, 1048577, 0));
        pending_chunks.push_back(mk(ones, ones, ones, 0, 2, 10, 4));
        pending_chunks.push_back(mk(ones, ones, ones, 0, 2, 10, 4));
        pending_chunks.push_back(mk(ones, ones, ones, 1, 3, 10, 4));
        pending_chunks.push_back(mk(ones, ones, ones, 1, 2, 11, 4));
        pending_chunks.push_back(mk(ones, ones, ones, 1, 2, 10, 6));
        pending_chunks.push_back(mk(1, 2, 3, 0, 2, 9, 4));
        pending_chunks.push_back(mk(1, 2, 3, 1, 2, 9, 4));
        pending_chunks.push_back(mk(5, 0, 0, 63, 64, 0, 1048577));
        pending_chunks.push_back(mk(6, 0, 0, 0, 1, 0, 1048576));
        pending_chunks.push_back(mk(7, 0, 0, 0, 1, 1048576, ones[31:0]));
        for (int k = 0; k < 17; k++) pending_chunks.push_back(mk(k, 9, 9, 0, 2, 0, 1));
        drain();

        // the extremes of the limits, with the table left full
        write_limit(CFG_MAX_INFLIGHT, 0);
        write_limit(CFG_MAX_CHUNKS, 0);
        write_limit(CFG_MAX_BYTES, 0);
        random_phase(60);
        write_limit(CFG_MAX_INFLIGHT, 5'd31);
        write_limit(CFG_MAX_CHUNKS, 7'd127);
        write_limit(CFG_MAX_BYTES, ones[31:0]);
        random_phase(300);
        write_limit(CFG_MAX_INFLIGHT, 3);
        write_limit(CFG_MAX_CHUNKS, 8);
        write_limit(CFG_MAX_BYTES, 900);
        random_phase(300);

        // long receiver hold-off while headers keep coming
        write_limit(CFG_MAX_INFLIGHT, 16);
        write_limit(CFG_MAX_CHUNKS, 64);
        write_limit(CFG_MAX_BYTES, MAX_BYTES_RST);
        hold_off_req <= 1'b1;
        random_phase(400);

        quiet_phase = 1'b1;
        random_phase(350);

        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0 && expected_verdicts.size() == 0 && !failed_timeout)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
